### src/bba_pkg.sv
// Package for the bitmap buffer allocator: sizes, codes, channel payloads
// and the request token that travels along the cell chain.
// No dependencies.
package bba_pkg;

  localparam int MAX_BUFFERS = 128;
  localparam int BLOCK_BYTES = 4096;

  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int IDX_W       = $clog2(MAX_BUFFERS);
  localparam int CNT_W       = 8;
  localparam int CELL_BITS   = 8;
  localparam int CELL_SHIFT  = $clog2(CELL_BITS);
  localparam int NUM_CELLS   = MAX_BUFFERS / CELL_BITS;
  localparam int CID_W       = IDX_W - CELL_SHIFT;

  localparam int IN_OFF_W  = 20;
  localparam int OUT_OFF_W = 19;
  localparam int OFFIDX_W  = IN_OFF_W - BLOCK_SHIFT;
  localparam int CMP_W     = (OFFIDX_W > CNT_W) ? OFFIDX_W : CNT_W;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  localparam logic [CFG_ADDR_W-3:0] REG_ACTIVE_BUFFERS = '0;
  localparam logic [CNT_W-1:0]      ACTIVE_RESET       = CNT_W'(93);
  localparam logic [CNT_W-1:0]      MAX_COUNT          = CNT_W'(MAX_BUFFERS);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_NO_FREE  = 2'd1,
    ERR_RANGE    = 2'd2,
    ERR_NOT_USED = 2'd3
  } err_t;

  typedef struct packed {
    logic                mode;
    logic [IN_OFF_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    logic                 ok;
    err_t                 error_code;
    logic [OUT_OFF_W-1:0] granted_offset;
    logic [CNT_W-1:0]     in_use_count;
    logic [CNT_W-1:0]     peak_in_use;
  } out_item_t;

  typedef struct packed {
    logic             valid;
    logic             alloc;
    logic             bad;
    logic             hit;
    logic [IDX_W-1:0] idx;
  } tok_t;

endpackage

### src/bba_cell.sv
// One cell of the allocator chain: holds the in-use bits of CELL_BITS
// buffers and serves the request token passing through it.
// Depends on bba_pkg.
module bba_cell import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [CID_W-1:0] cell_id,
  input  logic [CNT_W-1:0] pool_n,
  input  tok_t             tok_i,
  output tok_t             tok_o
);

  logic [CELL_BITS-1:0]  bits_r, bits_nxt;
  tok_t                  tok_r, tok_nxt;
  logic [CELL_BITS-1:0]  in_rng;
  logic                  found;
  logic [CELL_SHIFT-1:0] pick;
  logic [CELL_SHIFT-1:0] jf;
  logic                  mine;

  always_comb begin
    for (int j = 0; j < CELL_BITS; j++) begin
      in_rng[j] = CNT_W'({cell_id, CELL_SHIFT'(j)}) < pool_n;
    end
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int j = 0; j < CELL_BITS; j++) begin
      if (!found && !bits_r[j] && in_rng[j]) begin
        found = 1'b1;
        pick  = CELL_SHIFT'(j);
      end
    end
  end

  assign jf   = tok_i.idx[CELL_SHIFT-1:0];
  assign mine = (tok_i.idx[IDX_W-1:CELL_SHIFT] == cell_id);

  always_comb begin
    bits_nxt = bits_r;
    tok_nxt  = tok_i;
    if (tok_i.valid && tok_i.alloc && !tok_i.hit && found) begin
      bits_nxt[pick] = 1'b1;
      tok_nxt.hit    = 1'b1;
      tok_nxt.idx    = {cell_id, pick};
    end
    if (tok_i.valid && !tok_i.alloc && !tok_i.bad && mine && bits_r[jf]) begin
      bits_nxt[jf] = 1'b0;
      tok_nxt.hit  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r       <= '0;
      tok_r.valid  <= 1'b0;
    end else if (en) begin
      bits_r <= bits_nxt;
      tok_r  <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

### src/bitmap_buffer_allocator_core.sv
// Top level of the bitmap buffer allocator: request entry, cell chain,
// counters, result register and configuration port.
// Depends on bba_pkg and bba_cell.
//
//   channel  | handshake          | payload
//   in_      | in_valid, in_stall | in_data (in_item_t)
//   out_     | out_valid, out_stall | out_data (out_item_t)
//   cfg_     | APB write/read     | active_buffers at address 0
//
// A transaction walks the chain one cell per cycle while the output is not
// stalled; its result is registered after the last cell, and the next
// transaction is taken only once the previous one has left the chain.
// Reset frees every buffer and clears both counters.
// A stalled result holds the chain; the input stalls while a transaction
// is in flight.
module bitmap_buffer_allocator_core import bba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [CNT_W-1:0]    active_r;
  logic [CNT_W-1:0]    pool_n;
  logic [CNT_W-1:0]    used_r, used_nxt;
  logic [CNT_W-1:0]    peak_r, peak_nxt;
  logic                inflight_r;
  logic                out_valid_r;
  out_item_t           out_r, out_nxt;
  logic                en;
  logic                accept;
  logic [OFFIDX_W-1:0] off_idx;
  tok_t                chain [NUM_CELLS+1];
  tok_t                last;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ACTIVE_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_BUFFERS) begin
      active_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[CFG_ADDR_W-1:2] == REG_ACTIVE_BUFFERS) begin
      cfg_prdata = CFG_DATA_W'(active_r);
    end
  end

  assign pool_n = (active_r > MAX_COUNT) ? MAX_COUNT : active_r;

  assign en       = !out_valid_r || !out_stall;
  assign in_stall = inflight_r || !en;
  assign accept   = in_valid && !in_stall;

  assign off_idx = in_data.free_offset[IN_OFF_W-1:BLOCK_SHIFT];

  always_comb begin
    chain[0].valid = accept;
    chain[0].alloc = (in_data.mode == MODE_ALLOC);
    chain[0].bad   = !(CMP_W'(off_idx) < CMP_W'(pool_n));
    chain[0].hit   = 1'b0;
    chain[0].idx   = off_idx[IDX_W-1:0];
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    bba_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .cell_id (CID_W'(k)),
      .pool_n  (pool_n),
      .tok_i   (chain[k]),
      .tok_o   (chain[k+1])
    );
  end

  assign last = chain[NUM_CELLS];

  always_comb begin
    used_nxt = used_r;
    peak_nxt = peak_r;
    out_nxt  = '0;
    if (last.hit) begin
      if (last.alloc) begin
        used_nxt = used_r + CNT_W'(1);
        out_nxt.granted_offset = OUT_OFF_W'({last.idx, {BLOCK_SHIFT{1'b0}}});
      end else begin
        used_nxt = used_r - CNT_W'(1);
      end
      out_nxt.ok         = 1'b1;
      out_nxt.error_code = ERR_NONE;
    end else if (last.alloc) begin
      out_nxt.error_code = ERR_NO_FREE;
    end else if (last.bad) begin
      out_nxt.error_code = ERR_RANGE;
    end else begin
      out_nxt.error_code = ERR_NOT_USED;
    end
    if (used_nxt > peak_r) begin
      peak_nxt = used_nxt;
    end
    out_nxt.in_use_count = used_nxt;
    out_nxt.peak_in_use  = peak_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r      <= '0;
      peak_r      <= '0;
      inflight_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        inflight_r <= 1'b1;
      end else if (en && last.valid) begin
        inflight_r <= 1'b0;
      end
      if (en) begin
        out_valid_r <= last.valid;
        if (last.valid) begin
          used_r <= used_nxt;
          peak_r <= peak_nxt;
          out_r  <= out_nxt;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
